[hw/rtl/reply_prefix_strip_and_space_collapse_macros.svh]
// Assertion macros for the subject-line packer. They expect clk and rst_n in scope.
`ifndef REPLY_PREFIX_STRIP_AND_SPACE_COLLAPSE_MACROS_SVH
`define REPLY_PREFIX_STRIP_AND_SPACE_COLLAPSE_MACROS_SVH
`ifndef SYNTH
`define RPSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RPSS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RPSS_ASSERT(lbl, prop, msg)
`define RPSS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[hw/rtl/rpss_pkg.sv]
package rpss_pkg;

  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 10;
  localparam int CNT_W       = 8;
  localparam int LOOKAHEAD   = 5;
  localparam int HOLD_W      = 3;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [LEN_W-1:0] LIMIT_RESET = 10'd255;

  // register index = paddr[APB_ADDR_W-1:2]
  localparam logic [APB_ADDR_W-3:0] REG_LENGTH_LIMIT = '0;

  localparam logic [CHAR_W-1:0] CH_R_UP  = 8'h52;
  localparam logic [CHAR_W-1:0] CH_R_LO  = 8'h72;
  localparam logic [CHAR_W-1:0] CH_E_UP  = 8'h45;
  localparam logic [CHAR_W-1:0] CH_E_LO  = 8'h65;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    PH_SCAN,
    PH_R,
    PH_RE,
    PH_NUM,
    PH_COPY,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEQ,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic [CHAR_W-1:0] c;
    logic              eol;
    logic              blank;
    logic              is_r;
    logic              is_e;
    logic              is_digit;
    logic              is_colon;
    logic              is_caret;
    logic              is_space;
  } item_t;

  typedef struct packed {
    logic              emit;
    logic              emit_done;
    phase_t            phase;
    logic [LEN_W-1:0]  written;
  } bk_status_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // "- (nf"
  function automatic logic [CHAR_W-1:0] marker_byte(input logic [HOLD_W-1:0] idx);
    logic [CHAR_W-1:0] b;
    case (idx)
      3'd0:    b = CH_DASH;
      3'd1:    b = CH_SPACE;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h6E;
      3'd4:    b = 8'h66;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/rpss_in_if.sv]
interface rpss_in_if;
  import rpss_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              end_of_line;

  modport source(output valid, char_in, end_of_line, input ready);
  modport sink(input valid, char_in, end_of_line, output ready);
endinterface

[hw/rtl/rpss_out_if.sv]
interface rpss_out_if;
  import rpss_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CHAR_W-1:0]       char_out;
  logic                    char_valid;
  logic                    done_res;
  logic signed [CNT_W-1:0] reply_count;
  logic [LEN_W-1:0]        packed_length;

  modport source(output valid, char_out, char_valid, done_res, reply_count, packed_length,
                 input ready);
  modport sink(input valid, char_out, char_valid, done_res, reply_count, packed_length,
               output ready);
endinterface

[hw/rtl/rpss_front.sv]
module rpss_front (
  rpss_in_if.sink          in_chan,
  input  logic             q_full,
  output logic             q_push,
  output rpss_pkg::item_t  q_item
);
  import rpss_pkg::*;

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;

  always_comb begin
    q_item.c        = in_chan.char_in;
    q_item.eol      = in_chan.end_of_line;
    q_item.blank    = is_blank(in_chan.char_in);
    q_item.is_r     = (in_chan.char_in == CH_R_UP) || (in_chan.char_in == CH_R_LO);
    q_item.is_e     = (in_chan.char_in == CH_E_UP) || (in_chan.char_in == CH_E_LO);
    q_item.is_digit = (in_chan.char_in >= CH_ZERO) && (in_chan.char_in <= CH_NINE);
    q_item.is_colon = (in_chan.char_in == CH_COLON);
    q_item.is_caret = (in_chan.char_in == CH_CARET);
    q_item.is_space = (in_chan.char_in == CH_SPACE);
  end
endmodule

[hw/rtl/rpss_fifo.sv]
module rpss_fifo #(
  parameter int DEPTH = rpss_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rpss_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output rpss_pkg::item_t  pop_item,
  output logic             empty
);
  import rpss_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FCNT_W = $clog2(DEPTH + 1);

  item_t              mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == FCNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end
endmodule

[hw/rtl/rpss_back.sv]
module rpss_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [rpss_pkg::LEN_W-1:0]      length_limit,
  input  logic                            q_empty,
  input  rpss_pkg::item_t                 q_item,
  output logic                            q_pop,
  rpss_out_if.source                      out_chan,
  output rpss_pkg::bk_status_t            status
);
  import rpss_pkg::*;

  bk_state_t          state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   num_r, num_nxt;
  logic               seen_r, seen_nxt;
  logic [CHAR_W-1:0]  held_r [LOOKAHEAD];
  logic [CHAR_W-1:0]  held_nxt [LOOKAHEAD];
  logic [HOLD_W-1:0]  hcnt_r, hcnt_nxt;
  logic [LEN_W-1:0]   written_r, written_nxt;
  logic               brun_r, brun_nxt;
  logic [HOLD_W-1:0]  pos_r, pos_nxt;
  logic [HOLD_W-1:0]  len_r, len_nxt;
  logic [1:0]         lit_r, lit_nxt;
  logic               dpend_r, dpend_nxt;

  logic               ov_r, ov_nxt;
  logic [CHAR_W-1:0]  oc_r, oc_nxt;
  logic               ocv_r, ocv_nxt;
  logic               od_r, od_nxt;
  logic [CNT_W-1:0]   ocnt_r, ocnt_nxt;
  logic [LEN_W-1:0]   olen_r, olen_nxt;

  logic               slot_free;
  logic               emit;
  logic               emit_done;
  logic [CHAR_W-1:0]  emit_char;
  logic               do_scan;
  logic [CHAR_W-1:0]  b;
  logic [CHAR_W-1:0]  digit;

  assign slot_free = !ov_r || out_chan.ready;
  assign q_pop     = (state_r == BK_IDLE) && !q_empty;
  assign b         = held_r[pos_r];
  assign digit     = q_item.c - CH_ZERO;

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    num_nxt     = num_r;
    seen_nxt    = seen_r;
    held_nxt    = held_r;
    hcnt_nxt    = hcnt_r;
    written_nxt = written_r;
    brun_nxt    = brun_r;
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    lit_nxt     = lit_r;
    dpend_nxt   = dpend_r;
    emit        = 1'b0;
    emit_done   = 1'b0;
    emit_char   = '0;
    do_scan     = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (q_pop) begin
          pos_nxt = '0;
          if (q_item.eol) begin
            dpend_nxt = 1'b1;
            state_nxt = BK_DONE;
            case (phase_r)
              PH_R: begin
                len_nxt   = 3'd1;
                lit_nxt   = 2'd1;
                state_nxt = BK_SEQ;
              end
              PH_RE: begin
                len_nxt   = 3'd2;
                lit_nxt   = 2'd2;
                state_nxt = BK_SEQ;
              end
              PH_NUM: begin
                count_nxt = count_r + (seen_r ? num_r : CNT_W'(1));
                num_nxt   = '0;
                seen_nxt  = 1'b0;
              end
              PH_COPY: begin
                if (hcnt_r != '0) begin
                  len_nxt   = hcnt_r;
                  lit_nxt   = 2'd1;
                  hcnt_nxt  = '0;
                  state_nxt = BK_SEQ;
                end
              end
              default: ;
            endcase
          end else begin
            case (phase_r)
              PH_SCAN: do_scan = 1'b1;
              PH_R: begin
                held_nxt[1] = q_item.c;
                if (q_item.is_e) begin
                  phase_nxt = PH_RE;
                end else begin
                  // broken prefix: release the R, then copy this byte
                  phase_nxt = PH_COPY;
                  len_nxt   = 3'd2;
                  lit_nxt   = 2'd1;
                  state_nxt = BK_SEQ;
                end
              end
              PH_RE: begin
                if (q_item.is_colon || q_item.is_space) begin
                  count_nxt = count_r + 1'b1;
                  phase_nxt = PH_SCAN;
                end else if (q_item.is_caret) begin
                  num_nxt   = '0;
                  seen_nxt  = 1'b0;
                  phase_nxt = PH_NUM;
                end else begin
                  held_nxt[2] = q_item.c;
                  phase_nxt   = PH_COPY;
                  len_nxt     = 3'd3;
                  lit_nxt     = 2'd2;
                  state_nxt   = BK_SEQ;
                end
              end
              PH_NUM: begin
                if (q_item.is_digit) begin
                  num_nxt  = (num_r << 3) + (num_r << 1) + digit;
                  seen_nxt = 1'b1;
                end else begin
                  count_nxt = count_r + (seen_r ? num_r : CNT_W'(1));
                  num_nxt   = '0;
                  seen_nxt  = 1'b0;
                  phase_nxt = PH_SCAN;
                  do_scan   = !q_item.is_colon;
                end
              end
              PH_COPY: begin
                held_nxt[hcnt_r] = q_item.c;
                if (hcnt_r == '0) begin
                  len_nxt   = 3'd1;
                  lit_nxt   = 2'd0;
                  state_nxt = BK_SEQ;
                end else if (q_item.c == marker_byte(hcnt_r)) begin
                  if (hcnt_r == HOLD_W'(LOOKAHEAD - 1)) begin
                    hcnt_nxt  = '0;
                    phase_nxt = PH_STOP;
                  end else begin
                    hcnt_nxt = hcnt_r + 1'b1;
                  end
                end else begin
                  // partial marker failed: '-' goes out literally, rest rescanned
                  hcnt_nxt  = '0;
                  len_nxt   = hcnt_r + 1'b1;
                  lit_nxt   = 2'd1;
                  state_nxt = BK_SEQ;
                end
              end
              default: ;
            endcase

            if (do_scan && !q_item.blank) begin
              held_nxt[0] = q_item.c;
              if (q_item.is_r) begin
                phase_nxt = PH_R;
              end else begin
                phase_nxt = PH_COPY;
                len_nxt   = 3'd1;
                lit_nxt   = 2'd0;
                state_nxt = BK_SEQ;
              end
            end
          end
        end
      end

      BK_SEQ: begin
        if (slot_free) begin
          if (phase_r != PH_STOP) begin
            if (written_r >= length_limit) begin
              phase_nxt = PH_STOP;
            end else if (pos_r < {1'b0, lit_r}) begin
              emit      = 1'b1;
              emit_char = b;
              brun_nxt  = 1'b0;
            end else if (b == CH_DASH) begin
              held_nxt[0] = b;
              hcnt_nxt    = 3'd1;
            end else if (is_blank(b)) begin
              if (!brun_r) begin
                emit      = 1'b1;
                emit_char = CH_SPACE;
                brun_nxt  = 1'b1;
              end
            end else begin
              emit      = 1'b1;
              emit_char = b;
              brun_nxt  = 1'b0;
            end
          end
          if (emit) begin
            written_nxt = written_r + 1'b1;
          end
          if (pos_r == len_r - 1'b1) begin
            state_nxt = dpend_r ? BK_DONE : BK_IDLE;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end

      BK_DONE: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_done   = 1'b1;
          phase_nxt   = PH_SCAN;
          count_nxt   = '0;
          num_nxt     = '0;
          seen_nxt    = 1'b0;
          hcnt_nxt    = '0;
          written_nxt = '0;
          brun_nxt    = 1'b0;
          dpend_nxt   = 1'b0;
          state_nxt   = BK_IDLE;
        end
      end

      default: state_nxt = BK_IDLE;
    endcase
  end

  // output register
  always_comb begin
    ov_nxt   = ov_r && !out_chan.ready;
    oc_nxt   = oc_r;
    ocv_nxt  = ocv_r;
    od_nxt   = od_r;
    ocnt_nxt = ocnt_r;
    olen_nxt = olen_r;
    if (emit) begin
      ov_nxt   = 1'b1;
      oc_nxt   = emit_char;
      ocv_nxt  = !emit_done;
      od_nxt   = emit_done;
      ocnt_nxt = emit_done ? count_r : '0;
      olen_nxt = emit_done ? written_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      phase_r   <= PH_SCAN;
      count_r   <= '0;
      num_r     <= '0;
      seen_r    <= 1'b0;
      hcnt_r    <= '0;
      written_r <= '0;
      brun_r    <= 1'b0;
      pos_r     <= '0;
      len_r     <= '0;
      lit_r     <= '0;
      dpend_r   <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      num_r     <= num_nxt;
      seen_r    <= seen_nxt;
      hcnt_r    <= hcnt_nxt;
      written_r <= written_nxt;
      brun_r    <= brun_nxt;
      pos_r     <= pos_nxt;
      len_r     <= len_nxt;
      lit_r     <= lit_nxt;
      dpend_r   <= dpend_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    oc_r   <= oc_nxt;
    ocv_r  <= ocv_nxt;
    od_r   <= od_nxt;
    ocnt_r <= ocnt_nxt;
    olen_r <= olen_nxt;
  end

  assign out_chan.valid         = ov_r;
  assign out_chan.char_out      = oc_r;
  assign out_chan.char_valid    = ocv_r;
  assign out_chan.done_res      = od_r;
  assign out_chan.reply_count   = ocnt_r;
  assign out_chan.packed_length = olen_r;

  assign status.emit      = emit;
  assign status.emit_done = emit_done;
  assign status.phase     = phase_r;
  assign status.written   = written_r;
endmodule

[hw/rtl/reply_prefix_strip_and_space_collapse.sv]
// Packs one subject line, one byte per item, closed by an end-of-line item. Leading
// whitespace and reply prefixes (Re:, "Re ", Re^, Re^N with optional colon, any case) are
// dropped and counted, whitespace runs become one space, and copying stops at the marker
// "- (nf" or at length_limit bytes (APB register 0, reset 255). The end-of-line item yields
// a final result with the wrapped signed prefix count and the packed length. Input items go
// into a small queue (QUEUE_DEPTH entries). The back end dequeues an item only while idle,
// then processes it, one held byte per step while the result register has room, before it
// takes the next item. The result register lets the next item be taken while a finished
// result waits.
`include "reply_prefix_strip_and_space_collapse_macros.svh"

module reply_prefix_strip_and_space_collapse #(
  parameter int QUEUE_DEPTH = rpss_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  rpss_in_if.sink                            in_chan,
  rpss_out_if.source                         out_chan,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rpss_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rpss_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rpss_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import rpss_pkg::*;

  logic [LEN_W-1:0] limit_r, limit_nxt;
  logic             cfg_wr;
  logic             cfg_hit;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  item_t            q_in_item;
  item_t            q_out_item;
  bk_status_t       bk_status;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_LENGTH_LIMIT);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = cfg_hit ? APB_DATA_W'(limit_r) : '0;

  always_comb begin
    limit_nxt = limit_r;
    if (cfg_wr && cfg_hit) begin
      limit_nxt = pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  rpss_front u_front (
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_in_item)
  );

  rpss_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .empty     (q_empty)
  );

  rpss_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .length_limit (limit_r),
    .q_empty      (q_empty),
    .q_item       (q_out_item),
    .q_pop        (q_pop),
    .out_chan     (out_chan),
    .status       (bk_status)
  );

  `RPSS_ASSERT(a_queue_no_overflow, !(q_push && q_full), "item queued while queue full")
  `RPSS_ASSERT_NEXT(a_char_counts, bk_status.emit && !bk_status.emit_done, bk_status.written == LEN_W'($past(bk_status.written) + 1'b1), "written count not advanced by char result")
  `RPSS_ASSERT_NEXT(a_done_clears_line, bk_status.emit && bk_status.emit_done, bk_status.written == '0 && bk_status.phase == PH_SCAN, "line state not cleared after final result")
endmodule

[tb/reply_prefix_strip_and_space_collapse_test.sv]
module reply_prefix_strip_and_space_collapse_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rpss_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 64;
  localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {REG_LENGTH_LIMIT, 2'b00};
  // "- (nf"
  localparam logic [CHAR_W-1:0] MARKER_SEQ [LOOKAHEAD] =
    '{CH_DASH, CH_SPACE, 8'h28, 8'h6E, 8'h66};

  typedef struct packed {
    logic [CHAR_W-1:0]       ch;
    logic                    cv;
    logic                    done;
    logic signed [CNT_W-1:0] cnt;
    logic [LEN_W-1:0]        len;
  } subject_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  rpss_in_if  in_chan();
  rpss_out_if out_chan();

  reply_prefix_strip_and_space_collapse dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // predictor state
  phase_t            ph;
  logic [CNT_W-1:0]  pfx_count;
  logic [CNT_W-1:0]  caret_num;
  bit                caret_digits;
  logic [CHAR_W-1:0] held [LOOKAHEAD];
  int unsigned       held_n;
  logic [LEN_W-1:0]  written;
  bit                blank_run;
  logic [LEN_W-1:0]  len_limit;

  subject_result_t   packed_subject_q[$];
  logic [CHAR_W-1:0] line_q[$];

  int tx_idle_pct;
  int rx_stall_pct;
  int mismatches;
  int bytes_sent;
  int lines_sent;
  int results_seen;

  function automatic bit is_ws(logic [CHAR_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void emit(logic [CHAR_W-1:0] c, bit cv, bit dn);
    subject_result_t r;
    r.ch   = c;
    r.cv   = cv;
    r.done = dn;
    r.cnt  = dn ? pfx_count : '0;
    r.len  = dn ? written : '0;
    packed_subject_q.push_back(r);
  endfunction

  function automatic bit has_room();
    if (ph == PH_STOP) return 1'b0;
    if (written >= len_limit) begin
      ph = PH_STOP;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void put_byte(logic [CHAR_W-1:0] c);
    emit(c, 1'b1, 1'b0);
    written++;
  endfunction

  function automatic void put_literal(logic [CHAR_W-1:0] c);
    if (!has_room()) return;
    put_byte(c);
    blank_run = 1'b0;
  endfunction

  function automatic void copy_plain(logic [CHAR_W-1:0] c);
    if (!has_room()) return;
    if (c == MARKER_SEQ[0]) begin
      held[0] = c;
      held_n  = 1;
      return;
    end
    if (is_ws(c)) begin
      if (!blank_run) begin
        put_byte(CH_SPACE);
        blank_run = 1'b1;
      end
      return;
    end
    put_byte(c);
    blank_run = 1'b0;
  endfunction

  // leading dash goes out as is, the rest is scanned again
  function automatic void release_held(int unsigned n);
    logic [CHAR_W-1:0] snap [LOOKAHEAD];
    int unsigned i;
    if (n > LOOKAHEAD) n = LOOKAHEAD;
    snap   = held;
    held_n = 0;
    if (n == 0) return;
    put_literal(snap[0]);
    for (i = 1; i < n; i++) copy_plain(snap[i]);
  endfunction

  function automatic void copy_body(logic [CHAR_W-1:0] c);
    int unsigned n;
    if (ph == PH_STOP) return;
    if (held_n == 0) begin
      copy_plain(c);
      return;
    end
    n = held_n;
    if (n < LOOKAHEAD && c == MARKER_SEQ[n]) begin
      held[n] = c;
      held_n  = n + 1;
      if (held_n >= LOOKAHEAD) begin
        held_n = 0;
        ph     = PH_STOP;
      end
      return;
    end
    if (n >= LOOKAHEAD) n = LOOKAHEAD - 1;
    held[n] = c;
    release_held(n + 1);
  endfunction

  function automatic void scan_byte(logic [CHAR_W-1:0] c);
    if (is_ws(c)) return;
    if (c == CH_R_UP || c == CH_R_LO) begin
      held[0] = c;
      ph      = PH_R;
      return;
    end
    ph = PH_COPY;
    copy_body(c);
  endfunction

  function automatic void add_caret_count();
    pfx_count    = pfx_count + (caret_digits ? caret_num : 8'd1);
    caret_num    = '0;
    caret_digits = 1'b0;
  endfunction

  function automatic void clear_line();
    ph           = PH_SCAN;
    pfx_count    = '0;
    caret_num    = '0;
    caret_digits = 1'b0;
    held_n       = 0;
    written      = '0;
    blank_run    = 1'b0;
  endfunction

  function automatic void predict_item(logic [CHAR_W-1:0] c, bit eol);
    if (eol) begin
      case (ph)
        PH_R:    put_literal(held[0]);
        PH_RE: begin
          put_literal(held[0]);
          put_literal(held[1]);
        end
        PH_NUM:  add_caret_count();
        PH_COPY: if (held_n > 0) release_held(held_n);
        default: ;
      endcase
      emit('0, 1'b0, 1'b1);
      clear_line();
      return;
    end
    case (ph)
      PH_SCAN: scan_byte(c);
      PH_R: begin
        if (c == CH_E_LO || c == CH_E_UP) begin
          held[1] = c;
          ph      = PH_RE;
        end else begin
          ph = PH_COPY;
          put_literal(held[0]);
          copy_body(c);
        end
      end
      PH_RE: begin
        if (c == CH_COLON || c == CH_SPACE) begin
          pfx_count++;
          ph = PH_SCAN;
        end else if (c == CH_CARET) begin
          caret_num    = '0;
          caret_digits = 1'b0;
          ph           = PH_NUM;
        end else begin
          ph = PH_COPY;
          put_literal(held[0]);
          put_literal(held[1]);
          copy_body(c);
        end
      end
      PH_NUM: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          caret_num    = CNT_W'(caret_num * 10 + (c - CH_ZERO));
          caret_digits = 1'b1;
        end else begin
          add_caret_count();
          ph = PH_SCAN;
          if (c != CH_COLON) scan_byte(c);
        end
      end
      PH_COPY: copy_body(c);
      default: ;
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    if (mismatches < 10) $display("%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    subject_result_t want;
    subject_result_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      got.ch   = out_chan.char_out;
      got.cv   = out_chan.char_valid;
      got.done = out_chan.done_res;
      got.cnt  = out_chan.reply_count;
      got.len  = out_chan.packed_length;
      if (packed_subject_q.size() == 0) begin
        note_mismatch($sformatf("unexpected item: char %02h cv %0b done %0b count %0d len %0d",
                                got.ch, got.cv, got.done, got.cnt, got.len));
      end else begin
        want = packed_subject_q.pop_front();
        if (got !== want)
          note_mismatch($sformatf({"mismatch: exp char %02h cv %0b done %0b count %0d len %0d,",
                                   " got char %02h cv %0b done %0b count %0d len %0d"},
                                  want.ch, want.cv, want.done, want.cnt, want.len,
                                  got.ch, got.cv, got.done, got.cnt, got.len));
      end
    end
  end

  // receiver backpressure
  always @(posedge clk)
    out_chan.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);

  // valid stays up after an accepted item; drop it on a gap or before a pause
  task automatic send_item(logic [CHAR_W-1:0] c, bit eol);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.char_in     <= c;
    in_chan.end_of_line <= eol;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_item(c, eol);
    bytes_sent++;
  endtask

  task automatic add_byte(logic [CHAR_W-1:0] b);
    line_q.push_back(b);
  endtask

  task automatic add_text(string s);
    foreach (s[i]) line_q.push_back(s[i]);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_item(line_q[i], 1'b0);
    send_item(CHAR_W'($urandom_range(255)), 1'b1);
    line_q.delete();
    lines_sent++;
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    in_chan.valid <= 1'b0;
    while (packed_subject_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (packed_subject_q.size() != 0)
      note_mismatch($sformatf("%0d items never arrived", packed_subject_q.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length_limit(logic [LEN_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= APB_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    len_limit = v;
  endtask

  function automatic logic [CHAR_W-1:0] rand_blank();
    return ($urandom_range(3) == 0) ? CH_SPACE : CHAR_W'(CH_TAB + $urandom_range(4));
  endfunction

  task automatic test_prefix_runs();
    send_line();
    // bare prefixes plus a large caret count: 1 + 200 + 1 wraps negative
    add_byte(CH_TAB);
    add_text("Re:rE^200Re^x");
    send_line();
    add_text(" re^7");
    send_line();
  endtask

  task automatic test_broken_prefixes();
    add_text("Rx");
    send_line();
    add_text("rE");
    send_line();
    add_text("r");
    send_line();
  endtask

  task automatic test_blank_collapse();
    add_text("a");
    add_byte(CH_SPACE);
    for (int b = CH_TAB; b <= CH_CR; b++) add_byte(CHAR_W'(b));
    add_byte(8'h08);
    add_byte(8'h0E);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("b ");
    send_line();
  endtask

  task automatic test_marker_stop();
    add_text("x- (y--- (nfz");
    send_line();
    // partial marker left over at end of line
    add_text("a- (n");
    send_line();
  endtask

  task automatic test_length_limit();
    drain_results();
    write_length_limit(10'd2);
    add_text("Re:abc");
    send_line();
    drain_results();
    write_length_limit(10'd1);
    add_text("Rx");
    send_line();
    drain_results();
    write_length_limit(10'd0);
    add_text("rE x");
    send_line();
    drain_results();
    write_length_limit(LIMIT_RESET);
  endtask

  task automatic build_random_line();
    int kind;
    int k;
    line_q.delete();
    if ($urandom_range(4) == 0) begin
      // noise
      repeat ($urandom_range(10)) add_byte(CHAR_W'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(2)) add_byte(rand_blank());
    repeat ($urandom_range(3)) begin
      add_byte($urandom_range(1) ? CH_R_UP : CH_R_LO);
      kind = $urandom_range(10);
      if (kind == 10) begin
        add_byte(CHAR_W'($urandom_range(255)));
      end else begin
        add_byte($urandom_range(1) ? CH_E_UP : CH_E_LO);
        case (kind)
          0, 1: add_byte(CH_COLON);
          2, 3: add_byte(CH_SPACE);
          4, 5, 6, 7: begin
            add_byte(CH_CARET);
            repeat ($urandom_range(3)) add_byte(CHAR_W'(CH_ZERO + $urandom_range(9)));
            if ($urandom_range(1)) add_byte(CH_COLON);
          end
          default: add_byte(CHAR_W'($urandom_range(255)));
        endcase
      end
      if ($urandom_range(3) == 0) add_byte(rand_blank());
    end
    repeat ($urandom_range(12)) begin
      case ($urandom_range(7))
        0: add_byte(rand_blank());
        1: repeat ($urandom_range(1, 3)) add_byte(rand_blank());
        2: begin
          k = $urandom_range(1, LOOKAHEAD - 1);
          for (int i = 0; i < k; i++) add_byte(MARKER_SEQ[i]);
        end
        3: if ($urandom_range(3) == 0)
             for (int i = 0; i < LOOKAHEAD; i++) add_byte(MARKER_SEQ[i]);
        4: add_byte(CHAR_W'($urandom_range(255)));
        default: add_byte(CHAR_W'($urandom_range(8'h21, 8'h7E)));
      endcase
    end
  endtask

  task automatic test_random_traffic();
    int start;
    bit paused;
    for (int p = 0; p < 4; p++) begin
      drain_results();
      case (p)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          write_length_limit(10'd1023);
        end
        1: begin
          tx_idle_pct  = 49;
          rx_stall_pct = 0;
          write_length_limit(LEN_W'($urandom_range(1, 12)));
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 49;
          write_length_limit(LIMIT_RESET);
        end
        default: begin
          tx_idle_pct  = 36;
          rx_stall_pct = 36;
          write_length_limit(LEN_W'($urandom_range(0, 40)));
        end
      endcase
      start  = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - start < PHASE_ITEMS) begin
        build_random_line();
        send_line();
        // let the output side run dry with input held off
        if (p == 3 && !paused && bytes_sent - start >= PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.char_in     = '0;
    in_chan.end_of_line = 1'b0;
    out_chan.ready      = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    tx_idle_pct         = 0;
    rx_stall_pct        = 0;
    mismatches          = 0;
    bytes_sent          = 0;
    lines_sent          = 0;
    results_seen        = 0;
    len_limit           = LIMIT_RESET;
    foreach (held[i]) held[i] = '0;
    clear_line();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_prefix_runs();
    test_broken_prefixes();
    test_blank_collapse();
    test_marker_stop();
    test_length_limit();
    test_random_traffic();
    drain_results();

    $display("ran %0d subject lines, %0d input bytes, %0d output items checked",
             lines_sent, bytes_sent, results_seen);
    $display("length limits 0 to 1023, four sender/receiver stall mixes, %0d mismatches",
             mismatches);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d items outstanding", packed_subject_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rpss_pkg.sv
hw/rtl/rpss_in_if.sv
hw/rtl/rpss_out_if.sv
hw/rtl/rpss_front.sv
hw/rtl/rpss_fifo.sv
hw/rtl/rpss_back.sv
hw/rtl/reply_prefix_strip_and_space_collapse.sv
tb/reply_prefix_strip_and_space_collapse_test.sv
